// ----- design/assert_macros.svh -----
// assertion helpers, clocked on i_clk and disabled in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/uer_pkg.sv -----
package uer_pkg;

    localparam int SOUND_SPEED_BASE    = 331;
    localparam int START_WAIT_EXTRA_US = 5800;
    localparam int OVERHEAD_US         = 5;

    localparam int TICK_W    = 16;
    localparam int TIME_W    = 15;
    localparam int DIST_W    = 8;
    localparam int FACTOR_W  = 6;
    localparam int SPEED_W   = 9;
    localparam int BIASED_W  = 11;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 8;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BUSY     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_ECHO  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP      = 1'd1;

    localparam logic [CFG_W-1:0] MAX_RANGE_RESET = 8'd200;
    localparam logic [CFG_W-1:0] TEMP_RESET      = 8'd20;

    localparam logic [TICK_W-1:0] LOW_TICKS  = 16'd4;
    localparam logic [TICK_W-1:0] HIGH_TICKS = 16'd10;

    // x/10 as (x*3277)>>15, exact for x below 16384
    localparam int               DIV10_W     = 12;
    localparam logic [DIV10_W-1:0] DIV10_MUL = 12'd3277;
    localparam int               DIV10_SHIFT = 15;
    localparam int               Q10_W       = 8;

    localparam logic [DIV10_W-1:0] BIASED_OFFSET = 12'd1280;
    localparam logic [SPEED_W-1:0] SPEED_OFFSET  = SPEED_W'(SOUND_SPEED_BASE - 128);
    localparam logic [TIME_W-1:0]  FACTOR_NUM    = 15'd10000;

    localparam int DIV_STEPS = TIME_W;
    localparam int MUL_STEPS = CFG_W;
    localparam int STEP_W    = 4;

endpackage

// ----- design/ultrasonic_echo_ranger_top.sv -----
// Ultrasonic ranger on a shared trigger/echo pin. Each input beat is one
// microsecond tick (op 0) or a start request (op 1) with the sampled echo level,
// and each gives exactly one result beat with the pin drive, a done flag, status,
// echo time and distance. A start from idle latches the sound-speed factor and the
// timeout from the two configuration registers; a finished good measurement
// divides the time by twice the factor. Both divisions run on one shared
// restoring divider, one quotient bit per cycle, and the timeout comes from a
// serial shift-add multiplier, one bit of the maximum range per cycle. The next
// input beat is taken while a result still waits in the output register.
// Configuration writes are always ready and belong in idle periods.
`include "assert_macros.svh"

module ultrasonic_echo_ranger_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_op,
    input  logic                            i_echo_level,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_trig_drive,
    output logic                            o_trig_level,
    output logic                            o_done_res,
    output logic [uer_pkg::STATUS_W-1:0]    o_status,
    output logic [uer_pkg::TIME_W-1:0]      o_echo_time_us,
    output logic [uer_pkg::DIST_W-1:0]      o_distance_cm,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [uer_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [uer_pkg::CFG_W-1:0]       i_cfg_data
);
    import uer_pkg::*;

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_LOW     = 3'd1;
    localparam logic [2:0] PH_HIGH    = 3'd2;
    localparam logic [2:0] PH_CHECK   = 3'd3;
    localparam logic [2:0] PH_WAIT    = 3'd4;
    localparam logic [2:0] PH_MEASURE = 3'd5;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SPD  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [CFG_W-1:0]    r_max_range;
    logic [CFG_W-1:0]    r_temp;
    logic [2:0]          r_phase;
    logic [2:0]          n_phase;
    logic [TICK_W-1:0]   r_tick;
    logic [TICK_W-1:0]   n_tick;
    logic [FACTOR_W-1:0] r_factor;
    logic [TIME_W-1:0]   r_timeout;
    logic [2:0]          r_seq;
    logic [STEP_W-1:0]   r_step;

    logic                r_res_drive;
    logic                r_res_level;
    logic                r_res_done;
    logic [STATUS_W-1:0] r_res_status;
    logic [TIME_W-1:0]   r_res_time;
    logic [DIST_W-1:0]   r_res_dist;

    logic                r_out_valid;
    logic                r_out_drive;
    logic                r_out_level;
    logic                r_out_done;
    logic [STATUS_W-1:0] r_out_status;
    logic [TIME_W-1:0]   r_out_time;
    logic [DIST_W-1:0]   r_out_dist;

    logic [BIASED_W-1:0] r_biased;
    logic [TIME_W-1:0]   r_dq;
    logic [SPEED_W-1:0]  r_rem;
    logic [SPEED_W-1:0]  r_dvs;
    logic                r_div_fac;
    logic [TIME_W-1:0]   r_mcand;
    logic [CFG_W-1:0]    r_mplier;
    logic [TIME_W-1:0]   r_acc;

    // per-beat step results
    logic                step_drive;
    logic                step_level;
    logic                step_done;
    logic [STATUS_W-1:0] step_status;
    logic [TIME_W-1:0]   step_time;
    logic                step_start;
    logic                step_div;

    logic                      in_acc;
    logic                      out_free;
    logic [DIV10_W-1:0]        temp_ext;
    logic [DIV10_W-1:0]        biased_full;
    logic [BIASED_W+DIV10_W-1:0] prod10;
    logic [SPEED_W-1:0]        speed;
    logic [SPEED_W:0]          rem_sh;
    logic                      qbit;
    logic [SPEED_W-1:0]        rem_next;
    logic [TIME_W-1:0]         dq_next;
    logic [TIME_W-1:0]         acc_next;
    logic [DIST_W-1:0]         dist_sat;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_seq != S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign o_out_valid    = r_out_valid;
    assign o_trig_drive   = r_out_drive;
    assign o_trig_level   = r_out_level;
    assign o_done_res     = r_out_done;
    assign o_status       = r_out_status;
    assign o_echo_time_us = r_out_time;
    assign o_distance_cm  = r_out_dist;

    // 6*t + 1280, always positive
    assign temp_ext    = {{(DIV10_W-CFG_W){r_temp[CFG_W-1]}}, r_temp};
    assign biased_full = (temp_ext << 2) + (temp_ext << 1) + BIASED_OFFSET;

    assign prod10 = {{DIV10_W{1'b0}}, r_biased} * {{BIASED_W{1'b0}}, DIV10_MUL};
    assign speed  = SPEED_OFFSET + {1'b0, prod10[DIV10_SHIFT +: Q10_W]};

    // restoring divider step
    assign rem_sh   = {r_rem, r_dq[TIME_W-1]};
    assign qbit     = (rem_sh >= {1'b0, r_dvs});
    assign rem_next = qbit ? SPEED_W'(rem_sh - {1'b0, r_dvs}) : rem_sh[SPEED_W-1:0];
    assign dq_next  = {r_dq[TIME_W-2:0], qbit};
    assign dist_sat = (r_dvs == '0) ? '0 :
                      (|dq_next[TIME_W-1:DIST_W]) ? {DIST_W{1'b1}} : dq_next[DIST_W-1:0];

    // shift-add multiplier step
    assign acc_next = r_mplier[0] ? TIME_W'(r_acc + r_mcand) : r_acc;

    always_comb begin
        logic [TICK_W-1:0] inc;
        logic [TICK_W:0]   meas_t;
        inc         = r_tick + 1'b1;
        meas_t      = {1'b0, inc} + (TICK_W+1)'(OVERHEAD_US);
        n_phase     = r_phase;
        n_tick      = r_tick;
        step_drive  = 1'b0;
        step_level  = 1'b0;
        step_done   = 1'b0;
        step_status = ST_OK;
        step_time   = '0;
        step_start  = 1'b0;
        step_div    = 1'b0;
        if (i_op) begin
            unique case (r_phase)
                PH_IDLE: begin
                    n_phase    = PH_LOW;
                    n_tick     = '0;
                    step_drive = 1'b1;
                    step_start = 1'b1;
                end
                PH_LOW: begin
                    step_drive = 1'b1;
                end
                PH_HIGH: begin
                    step_drive = 1'b1;
                    step_level = 1'b1;
                end
                default: begin
                end
            endcase
        end else begin
            unique case (r_phase)
                PH_LOW: begin
                    step_drive = 1'b1;
                    if (inc >= LOW_TICKS) begin
                        n_phase = PH_HIGH;
                        n_tick  = '0;
                    end else begin
                        n_tick = inc;
                    end
                end
                PH_HIGH: begin
                    step_drive = 1'b1;
                    step_level = 1'b1;
                    if (inc >= HIGH_TICKS) begin
                        n_phase = PH_CHECK;
                        n_tick  = '0;
                    end else begin
                        n_tick = inc;
                    end
                end
                PH_CHECK: begin
                    if (i_echo_level) begin
                        n_phase     = PH_IDLE;
                        step_done   = 1'b1;
                        step_status = ST_BUSY;
                    end else begin
                        n_phase = PH_WAIT;
                        n_tick  = '0;
                    end
                end
                PH_WAIT: begin
                    if (i_echo_level) begin
                        n_phase = PH_MEASURE;
                        n_tick  = '0;
                    end else if ({1'b0, inc} > ({2'b0, r_timeout}
                                 + (TICK_W+1)'(START_WAIT_EXTRA_US))) begin
                        n_phase     = PH_IDLE;
                        n_tick      = '0;
                        step_done   = 1'b1;
                        step_status = ST_NO_ECHO;
                    end else begin
                        n_tick = inc;
                    end
                end
                PH_MEASURE: begin
                    if (!i_echo_level) begin
                        n_phase   = PH_IDLE;
                        n_tick    = '0;
                        step_done = 1'b1;
                        step_div  = 1'b1;
                        step_time = (|meas_t[TICK_W:TIME_W]) ? {TIME_W{1'b1}}
                                                             : meas_t[TIME_W-1:0];
                    end else if (inc > {1'b0, r_timeout}) begin
                        n_phase     = PH_IDLE;
                        n_tick      = '0;
                        step_done   = 1'b1;
                        step_status = ST_TOO_LONG;
                    end else begin
                        n_tick = inc;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_range <= MAX_RANGE_RESET;
            r_temp      <= TEMP_RESET;
            r_phase     <= PH_IDLE;
            r_tick      <= '0;
            r_factor    <= '0;
            r_timeout   <= '0;
            r_seq       <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_MAX_RANGE: r_max_range <= i_cfg_data;
                    CFG_TEMP:      r_temp      <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (r_seq == S_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_seq)
                S_IDLE: begin
                    if (in_acc) begin
                        r_phase <= n_phase;
                        r_tick  <= n_tick;
                        r_step  <= '0;
                        if (step_start) begin
                            r_seq <= S_SPD;
                        end else if (step_div) begin
                            r_seq <= S_DIV;
                        end else begin
                            r_seq <= S_FIN;
                        end
                    end
                end
                S_SPD: begin
                    r_seq <= S_DIV;
                end
                S_DIV: begin
                    if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                        r_step <= '0;
                        if (r_div_fac) begin
                            r_factor <= dq_next[FACTOR_W-1:0];
                            r_seq    <= S_MUL;
                        end else begin
                            r_seq <= S_FIN;
                        end
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_MUL: begin
                    if (r_step == STEP_W'(MUL_STEPS - 1)) begin
                        r_step    <= '0;
                        r_timeout <= acc_next;
                        r_seq     <= S_FIN;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_seq <= S_IDLE;
                    end
                end
                default: begin
                    r_seq <= S_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (r_seq == S_IDLE && in_acc) begin
            r_res_drive  <= step_drive;
            r_res_level  <= step_level;
            r_res_done   <= step_done;
            r_res_status <= step_status;
            r_res_time   <= step_time;
            r_res_dist   <= '0;
            r_biased     <= biased_full[BIASED_W-1:0];
            r_dq         <= step_time;
            r_rem        <= '0;
            r_dvs        <= {{(SPEED_W-FACTOR_W-1){1'b0}}, r_factor, 1'b0};
            r_div_fac    <= 1'b0;
        end
        if (r_seq == S_SPD) begin
            r_dq      <= FACTOR_NUM;
            r_rem     <= '0;
            r_dvs     <= speed;
            r_div_fac <= 1'b1;
        end
        if (r_seq == S_DIV) begin
            r_dq  <= dq_next;
            r_rem <= rem_next;
            if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                if (r_div_fac) begin
                    r_mcand  <= {{(TIME_W-FACTOR_W-1){1'b0}}, dq_next[FACTOR_W-1:0], 1'b0};
                    r_mplier <= r_max_range;
                    r_acc    <= '0;
                end else begin
                    r_res_dist <= dist_sat;
                end
            end
        end
        if (r_seq == S_MUL) begin
            r_acc    <= acc_next;
            r_mcand  <= {r_mcand[TIME_W-2:0], 1'b0};
            r_mplier <= {1'b0, r_mplier[CFG_W-1:1]};
        end
        if (r_seq == S_FIN && out_free) begin
            r_out_drive  <= r_res_drive;
            r_out_level  <= r_res_level;
            r_out_done   <= r_res_done;
            r_out_status <= r_res_status;
            r_out_time   <= r_res_time;
            r_out_dist   <= r_res_dist;
        end
    end

    `ASSERT_NXT(a_busy_after_accept, in_acc, r_seq != S_IDLE, "accepted beat left no work")
    `ASSERT_NXT(a_fin_loads_out, r_seq == S_FIN && !r_out_valid, r_out_valid,
        "finished result not loaded")
    `ASSERT_IMP(a_ok_has_factor, r_out_valid && r_out_done && r_out_status == ST_OK,
        r_factor != '0, "good measurement without factor")
    `ASSERT_IMP(a_measure_in_limit, r_phase == PH_MEASURE, r_tick <= {1'b0, r_timeout},
        "echo count beyond timeout")

endmodule
